/* src/byte_set_trim_top_assert.svh */
// assertion macros for the byte set trim block
// used by byte_set_trim_top; no other dependencies
`ifndef BYTE_SET_TRIM_TOP_ASSERT_SVH
`define BYTE_SET_TRIM_TOP_ASSERT_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define BST_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("byte_set_trim assertion failed");
// antecedent implies consequent in the next cycle
`define BST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("byte_set_trim assertion failed");
`else
`define BST_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define BST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* src/bst_pkg.sv */
// shared types and constants for the byte set trim block
// no dependencies; used by bst_front, bst_queue, bst_back and byte_set_trim_top
package bst_pkg;

  // default sizes
  localparam int SET_SIZE_DEF      = 8;
  localparam int PENDING_DEPTH_DEF = 32;
  localparam int QUEUE_DEPTH       = 2;
  localparam int QAW               = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIM_MODE = 2'd2;

  // register reset values (set holds a single space)
  localparam logic [63:0] SET_BYTES_RST = 64'h20;
  localparam logic [3:0]  SET_COUNT_RST = 4'd1;
  localparam logic [1:0]  TRIM_MODE_RST = 2'd3;

  // command kinds passed from front to back
  localparam logic [1:0] CMD_END  = 2'd0;
  localparam logic [1:0] CMD_HOLD = 2'd1;
  localparam logic [1:0] CMD_KEEP = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* src/bst_ram.sv */
// generic single write, single read ram with registered read data
// no dependencies
module bst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/bst_queue.sv */
// short command queue between the trim front and back
// depends on bst_pkg
module bst_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bst_pkg::cmd_t      wdata,
  input  logic               pop,
  output bst_pkg::cmd_t      rdata,
  output bst_pkg::q_status_t stat
);
  import bst_pkg::*;

  localparam int LW = $clog2(QUEUE_DEPTH + 1);

  cmd_t           entry_r [QUEUE_DEPTH];
  logic [QAW-1:0] wptr_r, wptr_nxt;
  logic [QAW-1:0] rptr_r, rptr_nxt;
  logic [LW-1:0]  level_r, level_nxt;
  logic           do_push, do_pop;

  assign stat.full  = (level_r == LW'(QUEUE_DEPTH));
  assign stat.empty = (level_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = entry_r[rptr_r];

  // pointer and level update
  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    level_nxt = level_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   level_nxt = level_r + 1'b1;
      2'b01:   level_nxt = level_r - 1'b1;
      default: level_nxt = level_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      level_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      level_r <= level_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wptr_r] <= wdata;
    end
  end

endmodule

/* src/bst_front.sv */
// trim front: config registers, set match and leading trim, command issue
// depends on bst_pkg
module bst_front #(
  parameter int SET_SIZE = bst_pkg::SET_SIZE_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [bst_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bst_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,
  input  logic                             in_tuser,
  input  logic                             in_tlast,
  input  bst_pkg::q_status_t               q_stat,
  output logic                             q_push,
  output bst_pkg::cmd_t                    q_wdata
);
  import bst_pkg::*;

  logic [63:0] set_bytes_r;
  logic [3:0]  set_count_r;
  logic [1:0]  trim_mode_r;
  logic        in_leading_r, in_leading_nxt;
  logic [3:0]  eff_count;
  logic        member, accept, drop, has_byte;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bytes_r <= SET_BYTES_RST;
      set_count_r <= SET_COUNT_RST;
      trim_mode_r <= TRIM_MODE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SET_BYTES: set_bytes_r <= cfg_wdata[63:0];
        CFG_SET_COUNT: set_count_r <= cfg_wdata[3:0];
        CFG_TRIM_MODE: trim_mode_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // set membership, count clamped to set size
  always_comb begin
    eff_count = (set_count_r > 4'(SET_SIZE)) ? 4'(SET_SIZE) : set_count_r;
    member    = 1'b0;
    for (int k = 0; k < SET_SIZE; k++) begin
      if ((4'(k) < eff_count) && (set_bytes_r[8*k +: 8] == in_tdata)) begin
        member = 1'b1;
      end
    end
  end

  // classify the item
  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign drop      = in_tuser && in_leading_r && trim_mode_r[0] && member;
  assign has_byte  = in_tuser && !drop;
  assign q_push    = accept && (has_byte || in_tlast);

  always_comb begin
    q_wdata.data = in_tdata;
    q_wdata.last = in_tlast;
    if (!has_byte) begin
      q_wdata.kind = CMD_END;
    end else if (trim_mode_r[1] && member) begin
      q_wdata.kind = CMD_HOLD;
    end else begin
      q_wdata.kind = CMD_KEEP;
    end
  end

  // leading flag: cleared by the first kept byte, set again at string end
  always_comb begin
    in_leading_nxt = in_leading_r;
    if (accept) begin
      if (in_tlast) begin
        in_leading_nxt = 1'b1;
      end else if (has_byte) begin
        in_leading_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_leading_r <= 1'b1;
    end else begin
      in_leading_r <= in_leading_nxt;
    end
  end

endmodule

/* src/bst_back.sv */
// trim back: pending ring buffer, flush sequencer and output register
// depends on bst_pkg and bst_ram
module bst_back #(
  parameter int PENDING_DEPTH = bst_pkg::PENDING_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bst_pkg::cmd_t      q_rdata,
  input  bst_pkg::q_status_t q_stat,
  output logic               q_pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,   // out_byte
  output logic [1:0]         out_tuser,   // out_valid, overflow
  output logic               out_tlast
);
  import bst_pkg::*;

  localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int CW = $clog2(PENDING_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_BYTE = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt, head_inc, tail;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW:0]   tail_sum;
  cmd_t          cmd_r, cmd_nxt;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata, ram_rdata;
  logic          slot_free, emit, end_only, pend_full;
  logic [7:0]    e_data;
  logic          e_valid, e_last, e_ovf;
  logic          out_tvalid_r;
  logic [7:0]    out_data_r;
  logic [1:0]    out_user_r;
  logic          out_last_r;

  // ring arithmetic
  assign head_inc  = (head_r == AW'(PENDING_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_sum  = (CW+1)'(head_r) + (CW+1)'(count_r);
  assign tail      = (tail_sum >= (CW+1)'(PENDING_DEPTH)) ?
                     AW'(tail_sum - (CW+1)'(PENDING_DEPTH)) : AW'(tail_sum);
  assign pend_full = (count_r == CW'(PENDING_DEPTH));
  assign slot_free = !out_tvalid_r || out_tready;

  // pending byte store, read address follows the next head
  bst_ram #(
    .WIDTH (8),
    .DEPTH (PENDING_DEPTH)
  ) u_pend (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head_nxt),
    .rdata (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    count_nxt = count_r;
    cmd_nxt   = cmd_r;
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = tail;
    ram_wdata = q_rdata.data;
    emit      = 1'b0;
    end_only  = 1'b0;
    e_data    = 8'd0;
    e_valid   = 1'b0;
    e_last    = 1'b0;
    e_ovf     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          case (q_rdata.kind)
            CMD_HOLD: begin
              if (pend_full) begin
                // oldest byte leaves early
                cmd_nxt   = q_rdata;
                q_pop     = 1'b1;
                state_nxt = S_RD;
              end else if (q_rdata.last) begin
                end_only = 1'b1;
              end else begin
                ram_we    = 1'b1;
                count_nxt = count_r + 1'b1;
                q_pop     = 1'b1;
              end
            end
            CMD_KEEP: begin
              if (count_r != '0) begin
                cmd_nxt   = q_rdata;
                q_pop     = 1'b1;
                state_nxt = S_RD;
              end else if (slot_free) begin
                emit    = 1'b1;
                e_data  = q_rdata.data;
                e_valid = 1'b1;
                e_last  = q_rdata.last;
                q_pop   = 1'b1;
                if (q_rdata.last) begin
                  head_nxt = '0;
                end
              end
            end
            default: begin
              end_only = 1'b1;
            end
          endcase
          // end marker with nothing to emit
          if (end_only && slot_free) begin
            emit      = 1'b1;
            e_last    = 1'b1;
            q_pop     = 1'b1;
            head_nxt  = '0;
            count_nxt = '0;
          end
        end
      end
      S_RD: begin
        if (slot_free) begin
          emit     = 1'b1;
          e_data   = ram_rdata;
          e_valid  = 1'b1;
          head_nxt = head_inc;
          if (cmd_r.kind == CMD_HOLD) begin
            // full ring: new byte takes the slot just freed
            e_ovf     = 1'b1;
            e_last    = cmd_r.last;
            ram_we    = 1'b1;
            ram_waddr = head_r;
            ram_wdata = cmd_r.data;
            state_nxt = S_IDLE;
            if (cmd_r.last) begin
              head_nxt  = '0;
              count_nxt = '0;
            end
          end else begin
            count_nxt = count_r - 1'b1;
            if (count_r == CW'(1)) begin
              state_nxt = S_BYTE;
            end
          end
        end
      end
      S_BYTE: begin
        if (slot_free) begin
          emit      = 1'b1;
          e_data    = cmd_r.data;
          e_valid   = 1'b1;
          e_last    = cmd_r.last;
          state_nxt = S_IDLE;
          if (cmd_r.last) begin
            head_nxt  = '0;
            count_nxt = '0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
    cmd_r <= cmd_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (slot_free) begin
      out_tvalid_r <= emit;
    end
    if (emit && slot_free) begin
      out_data_r <= e_data;
      out_user_r <= {e_ovf, e_valid};
      out_last_r <= e_last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

/* src/byte_set_trim_top.sv */
// top level of the byte set trim block: front, command queue and back
// depends on bst_pkg, bst_front, bst_queue, bst_back and the assertion header
//
// Strips bytes of a configured set (up to eight bytes) from the start, the
// end or both ends of each string. The front takes one item per cycle while
// the two-entry command queue has room; leading set bytes are dropped there.
// The back handles a kept byte with nothing held, and a held trailing set
// byte, in its idle state; a kept byte after n held bytes goes through a
// start step, n reads of the pending ring memory at one byte per cycle
// while the output is not stalled, then the byte, so a string's throughput
// is set by the back's flush loop. A full ring releases its oldest byte with
// the overflow flag. Each string end gives one result marked last.
`include "byte_set_trim_top_assert.svh"

module byte_set_trim_top #(
  parameter int SET_SIZE      = bst_pkg::SET_SIZE_DEF,
  parameter int PENDING_DEPTH = bst_pkg::PENDING_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bst_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bst_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // data_byte
  input  logic                           in_tuser,   // byte_present
  input  logic                           in_tlast,   // string_end
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // out_byte
  output logic [1:0]                     out_tuser,  // out_valid, overflow
  output logic                           out_tlast   // out_last
);
  import bst_pkg::*;

  q_status_t q_stat;
  cmd_t      q_wdata, q_rdata;
  logic      q_push, q_pop;

  // classify and issue commands
  bst_front #(
    .SET_SIZE (SET_SIZE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  // decoupling queue
  bst_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // pending buffer and result output
  bst_back #(
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_rdata    (q_rdata),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // input stalls whenever the queue is full
  `BST_ASSERT_SAME(a_full_stall, clk, rst_n, q_stat.full, !in_tready)
  // an end-only result carries no byte, no overflow and is last
  `BST_ASSERT_SAME(a_end_only, clk, rst_n, out_tvalid && !out_tuser[0], out_tlast && (out_tdata == 8'd0) && !out_tuser[1])
  // an overflow result always carries a byte
  `BST_ASSERT_SAME(a_ovf_byte, clk, rst_n, out_tvalid && out_tuser[1], out_tuser[0])
  // a popped command never comes from an empty queue
  `BST_ASSERT_SAME(a_pop_nonempty, clk, rst_n, q_pop, !q_stat.empty)

endmodule

/* tb/byte_set_trim_checker.sv */
// result checker for byte_set_trim_top: predicts trimmed bytes from observed items
// and config writes, then compares every accepted result in order
// depends on bst_pkg only
module byte_set_trim_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bst_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bst_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // data_byte
  input  logic                           in_tuser,   // byte_present
  input  logic                           in_tlast,   // string_end
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [7:0]                     out_tdata,  // out_byte
  input  logic [1:0]                     out_tuser,  // out_valid, overflow
  input  logic                           out_tlast,  // out_last
  output int                             err_count,
  output int                             results_due
);
  import bst_pkg::*;

  localparam int RING_DEPTH = PENDING_DEPTH_DEF;
  localparam int SET_MAX    = SET_SIZE_DEF;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       ovf;
    logic       last;
  } trim_res_t;

  // shadow of the config registers
  logic [63:0] set_bytes_r;
  logic [3:0]  set_count_r;
  logic [1:0]  trim_mode_r;

  // shadow of the trim state
  logic        leading;
  logic [7:0]  held_bytes [RING_DEPTH];
  int          held_count;
  int          held_head;

  trim_res_t   trimmed_q [$];
  int          mismatches;

  // set membership, count clamped to the set size
  function automatic bit in_trim_set(input logic [7:0] b);
    int n;
    bit hit;
    n = (set_count_r > SET_MAX) ? SET_MAX : int'(set_count_r);
    hit = 1'b0;
    for (int k = 0; k < n; k++)
      if (set_bytes_r[8*k +: 8] == b) hit = 1'b1;
    return hit;
  endfunction

  // expected results of one accepted item
  task automatic predict_trim(input logic [7:0] b, input logic present, input logic str_end);
    int        n;
    bit        member;
    trim_res_t tail;
    n = 0;
    if (present) begin
      member = in_trim_set(b);
      if (!(leading && trim_mode_r[0] && member)) begin
        leading = 1'b0;
        if (trim_mode_r[1] && member) begin
          // ring full: oldest held byte leaves early
          if (held_count >= RING_DEPTH) begin
            trimmed_q.push_back(trim_res_t'{held_bytes[held_head], 1'b1, 1'b1, 1'b0});
            n++;
            held_head = (held_head + 1) % RING_DEPTH;
            held_count = RING_DEPTH - 1;
          end
          held_bytes[(held_head + held_count) % RING_DEPTH] = b;
          held_count++;
        end else begin
          // flush held run oldest first, then the kept byte
          while (held_count > 0) begin
            trimmed_q.push_back(trim_res_t'{held_bytes[held_head], 1'b1, 1'b0, 1'b0});
            n++;
            held_head = (held_head + 1) % RING_DEPTH;
            held_count--;
          end
          trimmed_q.push_back(trim_res_t'{b, 1'b1, 1'b0, 1'b0});
          n++;
        end
      end
    end
    if (str_end) begin
      held_count = 0;
      held_head = 0;
      leading = 1'b1;
      if (n > 0) begin
        tail = trimmed_q.pop_back();
        tail.last = 1'b1;
        trimmed_q.push_back(tail);
      end else begin
        trimmed_q.push_back(trim_res_t'{8'h00, 1'b0, 1'b0, 1'b1});
      end
    end
  endtask

  always @(posedge clk) begin : watch
    trim_res_t got;
    trim_res_t want;
    if (!rst_n) begin
      set_bytes_r = SET_BYTES_RST;
      set_count_r = SET_COUNT_RST;
      trim_mode_r = TRIM_MODE_RST;
      leading = 1'b1;
      held_count = 0;
      held_head = 0;
      trimmed_q.delete();
      mismatches = 0;
    end else begin
      // compare an accepted result with the oldest expectation
      if (out_tvalid && out_tready) begin
        got = trim_res_t'{out_tdata, out_tuser[0], out_tuser[1], out_tlast};
        if (trimmed_q.size() == 0) begin
          $error("result with none expected: out_byte %0h out_valid %0b overflow %0b out_last %0b",
                 got.data, got.valid, got.ovf, got.last);
          mismatches++;
        end else begin
          want = trimmed_q.pop_front();
          if (got.data !== want.data) begin
            $error("out_byte mismatch: expected %0h, actual %0h", want.data, got.data);
            mismatches++;
          end
          if (got.valid !== want.valid) begin
            $error("out_valid mismatch: expected %0b, actual %0b", want.valid, got.valid);
            mismatches++;
          end
          if (got.ovf !== want.ovf) begin
            $error("overflow mismatch: expected %0b, actual %0b", want.ovf, got.ovf);
            mismatches++;
          end
          if (got.last !== want.last) begin
            $error("out_last mismatch: expected %0b, actual %0b", want.last, got.last);
            mismatches++;
          end
        end
      end
      // accepted input item
      if (in_tvalid && in_tready) predict_trim(in_tdata, in_tuser, in_tlast);
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_SET_BYTES: set_bytes_r = cfg_wdata;
          CFG_SET_COUNT: set_count_r = cfg_wdata[3:0];
          CFG_TRIM_MODE: trim_mode_r = cfg_wdata[1:0];
          default: ;
        endcase
      end
    end
    err_count <= mismatches;
    results_due <= trimmed_q.size();
  end

endmodule

/* tb/tb.sv */
// testbench top for byte_set_trim_top: clock, reset, string stimulus, config phases
// and verdict; prediction and comparison live in byte_set_trim_checker
// depends on bst_pkg, byte_set_trim_top and byte_set_trim_checker
module tb;
  import bst_pkg::*;

  localparam int LIMIT_CYCLES   = 400000;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES  = 64;
  localparam int GAP_PCT        = 38;
  localparam int PHASE_ITEMS    = 2;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = 8'h00;   // data_byte
  logic                  in_tuser = 1'b0;    // byte_present
  logic                  in_tlast = 1'b0;    // string_end
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;          // out_byte
  logic [1:0]            out_tuser;          // out_valid, overflow
  logic                  out_tlast;          // out_last

  int          err_count;
  int          results_due;
  bit          tx_gaps = 1'b1;
  bit          rx_gaps = 1'b1;
  bit          hold_off_req = 1'b0;
  logic [63:0] cur_set = SET_BYTES_RST;
  logic [3:0]  cur_count = SET_COUNT_RST;
  int          items_sent = 0;

  always #6 clk = ~clk;

  byte_set_trim_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  byte_set_trim_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .err_count   (err_count),
    .results_due (results_due)
  );

  // result side: random stalls, gap-free stretches and one long hold-off
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_left = RX_HOLD_CYCLES;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (!rx_gaps) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= GAP_PCT);
      end
    end
  end

  // watchdog
  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("byte_set_trim_top regression: fail");
    $finish;
  end

  // a byte of the current set, or any byte when the set is empty
  function automatic logic [7:0] pick_set_byte();
    int n;
    n = (cur_count > SET_SIZE_DEF) ? SET_SIZE_DEF : int'(cur_count);
    if (n == 0) return 8'($urandom_range(0, 255));
    return cur_set[8*$urandom_range(0, n - 1) +: 8];
  endfunction

  // offer one item and hold it until accepted
  task automatic send_item(input logic [7:0] b, input logic present, input logic str_end);
    while (tx_gaps && $urandom_range(0, 99) < GAP_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= present;
    in_tlast  <= str_end;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (present || str_end) items_sent++;
  endtask

  // stop offering and wait for every expected result
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  // new register setting, written only while the block is idle
  task automatic load_setup(input logic [63:0] sb, input logic [3:0] cnt, input logic [1:0] mode);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SET_BYTES;
    cfg_wdata <= sb;
    @(posedge clk);
    cfg_index <= CFG_SET_COUNT;
    cfg_wdata <= {60'd0, cnt};
    @(posedge clk);
    cfg_index <= CFG_TRIM_MODE;
    cfg_wdata <= {62'd0, mode};
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_set   = sb;
    cur_count = cnt;
  endtask

  // one string: leading set run, mixed middle, trailing set run, optional kept byte
  task automatic send_string(input int trail_len, input bit flush, input logic [7:0] kept);
    logic [7:0] str_q [$];
    bit         end_on_byte;
    int         lead;
    int         mid;
    lead = $urandom_range(0, 3);
    mid = $urandom_range(0, 6);
    end_on_byte = ($urandom_range(0, 1) == 1);
    for (int i = 0; i < lead; i++) str_q.push_back(pick_set_byte());
    for (int i = 0; i < mid; i++)
      str_q.push_back(($urandom_range(0, 99) < 40) ? pick_set_byte() :
                      8'($urandom_range(0, 255)));
    // long runs need kept data in front to reach the pending ring
    if (trail_len > 4) str_q.push_back(kept);
    for (int i = 0; i < trail_len; i++) str_q.push_back(pick_set_byte());
    if (flush) str_q.push_back(kept);
    foreach (str_q[i]) begin
      if ($urandom_range(0, 9) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(str_q[i], 1'b1, end_on_byte && (i == str_q.size() - 1));
    end
    if (!end_on_byte || str_q.size() == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // random strings until the item budget of the phase is used
  task automatic run_phase(input int budget);
    int start;
    start = items_sent;
    while (items_sent - start < budget) begin
      if ($urandom_range(0, 11) == 0)
        send_string($urandom_range(33, 40), ($urandom_range(0, 1) == 1),
                    8'($urandom_range(0, 255)));
      else
        send_string($urandom_range(0, 4), ($urandom_range(0, 2) == 0),
                    8'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) == 0) drain_results();
    end
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed strings at the reset setting: space set, both ends
    send_item(8'h00, 1'b0, 1'b1);   // bare end marker
    send_item(8'h20, 1'b1, 1'b0);   // leading set byte dropped
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h20, 1'b1, 1'b0);
    send_item(8'h20, 1'b1, 1'b0);
    send_item(8'hAA, 1'b0, 1'b0);   // bare item, no effect
    send_item(8'hFF, 1'b1, 1'b0);   // flush of two held bytes
    send_item(8'h20, 1'b1, 1'b0);
    send_item(8'h20, 1'b1, 1'b1);   // held run dropped at end
    send_item(8'h55, 1'b1, 1'b1);
    send_item(8'h20, 1'b1, 1'b1);   // only a set byte in the string
    send_item(8'h41, 1'b1, 1'b0);
    send_item(8'h20, 1'b1, 1'b0);
    send_item(8'h42, 1'b1, 1'b1);
    send_item(8'h20, 1'b0, 1'b1);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h7F, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h20, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);   // bare end after held byte

    // full set, both ends; long run while the receiver holds off
    load_setup(64'hFF002E2D0D0A0920, 4'd8, 2'd3);
    hold_off_req = 1'b1;
    send_string(36, 1'b1, 8'h41);
    run_phase(PHASE_ITEMS);

    // empty set
    load_setup(64'hFF002E2D0D0A0920, 4'd0, 2'd3);
    run_phase(PHASE_ITEMS);

    // leading and trailing only, without any idling
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    load_setup(64'h0000000000005830, 4'd2, 2'd1);
    run_phase(PHASE_ITEMS);
    load_setup(64'h00000000002C3B2E, 4'd3, 2'd2);
    run_phase(PHASE_ITEMS);
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;

    // trim mode zero passes everything
    load_setup({$urandom, $urandom}, 4'd4, 2'd0);
    run_phase(PHASE_ITEMS);

    // oversized count, all-ones set
    load_setup(64'hFFFFFFFFFFFFFFFF, 4'd15, 2'd3);
    run_phase(PHASE_ITEMS);

    // all-zero set, trailing only; run ends while the ring overflows
    load_setup(64'h0000000000000000, 4'd8, 2'd2);
    send_string(34, 1'b0, 8'h41);
    run_phase(PHASE_ITEMS);

    // random settings
    repeat (3) begin
      load_setup({$urandom, $urandom}, 4'($urandom_range(0, 15)), 2'($urandom_range(1, 3)));
      run_phase(PHASE_ITEMS);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("byte_set_trim_top regression: pass");
    end else begin
      $display("byte_set_trim_top regression: fail");
    end
    $finish;
  end

endmodule
